@@ rtl/bblru_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bblru_pkg
// Types and codes shared by the byte-budget LRU cache directory.
// ----------------------------------------------------------------------------
package bblru_pkg;

   localparam logic [2:0] MODE_INSERT   = 3'd0;
   localparam logic [2:0] MODE_LOOKUP   = 3'd1;
   localparam logic [2:0] MODE_CONTAINS = 3'd2;
   localparam logic [2:0] MODE_ERASE    = 3'd3;
   localparam logic [2:0] MODE_CLEAR    = 3'd4;

   localparam logic CSR_BUDGET   = 1'b0;
   localparam logic CSR_OVERHEAD = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] key;
      logic [31:0] payload_length;
      logic [31:0] payload_handle;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        found;
      logic [31:0] handle_out;
      logic [31:0] bytes_in_use;
   } rsp_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,      // capture request, compute cost
      OP_SCAN,      // walk one slot: match, free, lru search
      OP_SCAN_INIT, // restart the slot walk
      OP_REMOVE,    // remove the slot held in the target register
      OP_PROMOTE,   // walk one slot updating ranks after a removal or for promotion
      OP_WRITE,     // write new entry into the free slot
      OP_CLEAR,     // drop all entries
      OP_RESULT     // load the result register
   } op_type;

   typedef struct packed {
      op_type op;
      logic   target_lru;   // OP_REMOVE: use lru slot, else matched slot
      logic   set_status;
      logic   set_found;
      logic   set_handle;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic hit;
      logic any_valid;
      logic full;
      logic too_big;
      logic over_budget;
   } sts_type;

endpackage
`default_nettype wire

@@ rtl/bblru_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bblru_datapath
// Entry store, rank store, byte totals and the slot walker.
// ----------------------------------------------------------------------------
module bblru_datapath #(
   parameter int ENTRIES = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  bblru_pkg::cmd_type  cmd,
   output bblru_pkg::sts_type  sts,
   input  bblru_pkg::req_type  req_payload,
   input  wire  [31:0]         budget,
   input  wire  [15:0]         overhead,
   output bblru_pkg::rsp_type  rsp_payload
);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   logic [ENTRIES-1:0] valid_ff;
   logic [63:0]        key_mem  [ENTRIES];
   logic [31:0]        cost_mem [ENTRIES];
   logic [31:0]        hdl_mem  [ENTRIES];
   logic [IW-1:0]      rank_mem [ENTRIES];

   bblru_pkg::req_type req_ff;
   logic [32:0]        cost_ff;
   logic [31:0]        used_ff;
   logic [CW-1:0]      count_ff;
   logic [IW-1:0]      idx_ff;
   logic [IW-1:0]      idx_next;
   logic [63:0]        key_rd_ff;
   logic [IW-1:0]      rank_rd_ff;
   logic [31:0]        cost_rd_ff;
   logic [31:0]        hdl_rd_ff;
   logic               hit_ff;
   logic [IW-1:0]      hit_slot_ff;
   logic [IW-1:0]      hit_rank_ff;
   logic [31:0]        hit_cost_ff;
   logic [31:0]        hit_hdl_ff;
   logic               free_ok_ff;
   logic [IW-1:0]      free_slot_ff;
   logic               lru_ok_ff;
   logic [IW-1:0]      lru_slot_ff;
   logic [IW-1:0]      lru_rank_ff;
   logic [31:0]        lru_cost_ff;
   logic [IW-1:0]      rm_rank_ff;
   logic               rm_pend_ff;
   bblru_pkg::rsp_type rsp_ff;

   logic [IW-1:0] tgt;
   logic [IW-1:0] tgt_rank;
   logic [31:0]   tgt_cost;
   assign tgt      = cmd.target_lru ? lru_slot_ff : hit_slot_ff;
   assign tgt_rank = cmd.target_lru ? lru_rank_ff : hit_rank_ff;
   assign tgt_cost = cmd.target_lru ? lru_cost_ff : hit_cost_ff;

   assign sts.scan_last   = (idx_ff == IW'(ENTRIES - 1));
   assign sts.hit         = hit_ff;
   assign sts.any_valid   = (count_ff != '0);
   assign sts.full        = (count_ff == CW'(ENTRIES));
   assign sts.too_big     = (cost_ff > {1'b0, budget});
   assign sts.over_budget = ({1'b0, used_ff} + cost_ff) > {1'b0, budget};
   assign rsp_payload     = rsp_ff;

   // slot walked in the next cycle; its entry is read into registers ahead of the walk
   always_comb begin
      unique case (cmd.op)
         bblru_pkg::OP_SCAN, bblru_pkg::OP_PROMOTE:
            idx_next = sts.scan_last ? '0 : idx_ff + IW'(1);
         bblru_pkg::OP_SCAN_INIT, bblru_pkg::OP_REMOVE, bblru_pkg::OP_WRITE:
            idx_next = '0;
         default: idx_next = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_rd_ff  <= key_mem[idx_next];
      rank_rd_ff <= rank_mem[idx_next];
      cost_rd_ff <= cost_mem[idx_next];
      hdl_rd_ff  <= hdl_mem[idx_next];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         used_ff    <= '0;
         count_ff   <= '0;
         idx_ff     <= '0;
         rm_pend_ff <= 1'b0;
      end else begin
         idx_ff <= idx_next;
         unique case (cmd.op)
            bblru_pkg::OP_LOAD: begin
               req_ff  <= req_payload;
               cost_ff <= {1'b0, req_payload.payload_length} + 33'(overhead);
            end
            bblru_pkg::OP_SCAN_INIT: begin
               hit_ff     <= 1'b0;
               free_ok_ff <= 1'b0;
               lru_ok_ff  <= 1'b0;
            end
            bblru_pkg::OP_SCAN: begin
               // one slot per cycle: key match, lowest free, highest rank
               if (valid_ff[idx_ff]) begin
                  if (key_rd_ff == req_ff.key) begin
                     hit_ff      <= 1'b1;
                     hit_slot_ff <= idx_ff;
                     hit_rank_ff <= rank_rd_ff;
                     hit_cost_ff <= cost_rd_ff;
                     hit_hdl_ff  <= hdl_rd_ff;
                  end
                  if (!lru_ok_ff || rank_rd_ff > lru_rank_ff) begin
                     lru_ok_ff   <= 1'b1;
                     lru_slot_ff <= idx_ff;
                     lru_rank_ff <= rank_rd_ff;
                     lru_cost_ff <= cost_rd_ff;
                  end
               end else if (!free_ok_ff) begin
                  free_ok_ff   <= 1'b1;
                  free_slot_ff <= idx_ff;
               end
            end
            bblru_pkg::OP_REMOVE: begin
               valid_ff[tgt] <= 1'b0;
               used_ff       <= used_ff - tgt_cost;
               count_ff      <= count_ff - CW'(1);
               rm_rank_ff    <= tgt_rank;
               rm_pend_ff    <= 1'b1;
            end
            bblru_pkg::OP_PROMOTE: begin
               // removal close-up or promotion, one slot per cycle
               if (valid_ff[idx_ff]) begin
                  if (rm_pend_ff) begin
                     if (rank_rd_ff > rm_rank_ff)
                        rank_mem[idx_ff] <= rank_rd_ff - IW'(1);
                  end else if (idx_ff == hit_slot_ff) begin
                     rank_mem[idx_ff] <= '0;
                  end else if (rank_rd_ff < hit_rank_ff) begin
                     rank_mem[idx_ff] <= rank_rd_ff + IW'(1);
                  end
               end
               if (sts.scan_last) rm_pend_ff <= 1'b0;
            end
            bblru_pkg::OP_WRITE: begin
               valid_ff[free_slot_ff] <= 1'b1;
               key_mem[free_slot_ff]  <= req_ff.key;
               cost_mem[free_slot_ff] <= cost_ff[31:0];
               hdl_mem[free_slot_ff]  <= req_ff.payload_handle;
               rank_mem[free_slot_ff] <= count_ff[IW-1:0];
               used_ff                <= used_ff + cost_ff[31:0];
               count_ff               <= count_ff + CW'(1);
               // promote the new slot from the bottom rank
               hit_slot_ff            <= free_slot_ff;
               hit_rank_ff            <= count_ff[IW-1:0];
            end
            bblru_pkg::OP_CLEAR: begin
               valid_ff <= '0;
               used_ff  <= '0;
               count_ff <= '0;
            end
            bblru_pkg::OP_RESULT: begin
               rsp_ff.status       <= cmd.set_status;
               rsp_ff.found        <= cmd.set_found;
               rsp_ff.handle_out   <= cmd.set_handle ? hit_hdl_ff : '0;
               rsp_ff.bytes_in_use <= used_ff;
            end
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("entry count beyond table size");
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == bblru_pkg::OP_CLEAR |=> used_ff == '0 && valid_ff == '0)
      else $error("clear left entries");
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == bblru_pkg::OP_WRITE |-> !valid_ff[free_slot_ff])
      else $error("write into occupied slot");
endmodule
`default_nettype wire

@@ rtl/bblru_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bblru_ctrl
// Sequencer for insert, lookup, contains, erase and clear.
// ----------------------------------------------------------------------------
module bblru_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [2:0]          req_mode,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output bblru_pkg::cmd_type  cmd,
   input  bblru_pkg::sts_type  sts
);
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_INIT    = 4'd2;
   localparam logic [3:0] S_SCAN    = 4'd3;
   localparam logic [3:0] S_ACT     = 4'd4;
   localparam logic [3:0] S_CLOSE   = 4'd5;
   localparam logic [3:0] S_EVICT   = 4'd6;
   localparam logic [3:0] S_WRITE   = 4'd7;
   localparam logic [3:0] S_PROMO   = 4'd8;
   localparam logic [3:0] S_RESULT  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [2:0] mode_ff, mode_in;
   logic       ins_ff, ins_in;      // insert: first scan done, key slot handled
   logic       st_ff, st_in;
   logic       fd_ff, fd_in;
   logic       hd_ff, hd_in;
   logic       out_ff, out_in;
   logic [3:0] after_ff, after_in;  // state after a rank close-up

   assign req_stall = (state_ff != S_IDLE) || out_ff;
   assign rsp_valid = out_ff;

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; ins_in = ins_ff;
      st_in = st_ff; fd_in = fd_ff; hd_in = hd_ff; after_in = after_ff;
      out_in = out_ff && rsp_stall;
      cmd = '{op: bblru_pkg::OP_NONE, target_lru: 1'b0,
              set_status: st_ff, set_found: fd_ff, set_handle: hd_ff};
      unique case (state_ff)
         S_IDLE: if (req_valid && !out_ff) begin
            cmd.op = bblru_pkg::OP_LOAD;
            mode_in = req_mode; ins_in = 1'b0;
            st_in = 1'b0; fd_in = 1'b0; hd_in = 1'b0;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            if (mode_ff == bblru_pkg::MODE_CLEAR) begin
               cmd.op = bblru_pkg::OP_CLEAR; state_in = S_RESULT;
            end else if (mode_ff > bblru_pkg::MODE_CLEAR) begin
               state_in = S_RESULT;
            end else if (mode_ff == bblru_pkg::MODE_INSERT && sts.too_big) begin
               st_in = 1'b1; state_in = S_RESULT;
            end else begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin cmd.op = bblru_pkg::OP_SCAN_INIT; state_in = S_SCAN; end
         S_SCAN: begin
            cmd.op = bblru_pkg::OP_SCAN;
            if (sts.scan_last) state_in = S_ACT;
         end
         S_ACT: begin
            case (mode_ff)
               bblru_pkg::MODE_INSERT: begin
                  if (!ins_ff && sts.hit) begin
                     cmd.op = bblru_pkg::OP_REMOVE; ins_in = 1'b1;
                     after_in = S_INIT; state_in = S_CLOSE;
                  end else if (sts.any_valid && (sts.over_budget || sts.full)) begin
                     cmd.op = bblru_pkg::OP_REMOVE; cmd.target_lru = 1'b1;
                     ins_in = 1'b1; after_in = S_INIT; state_in = S_CLOSE;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
               bblru_pkg::MODE_LOOKUP: begin
                  if (sts.hit) begin
                     fd_in = 1'b1; hd_in = 1'b1; state_in = S_PROMO;
                  end else state_in = S_RESULT;
               end
               bblru_pkg::MODE_CONTAINS: begin
                  fd_in = sts.hit; state_in = S_RESULT;
               end
               default: begin
                  if (sts.hit) begin
                     cmd.op = bblru_pkg::OP_REMOVE; fd_in = 1'b1;
                     after_in = S_RESULT; state_in = S_CLOSE;
                  end else state_in = S_RESULT;
               end
            endcase
         end
         S_CLOSE: begin
            cmd.op = bblru_pkg::OP_PROMOTE;
            if (sts.scan_last) state_in = after_ff;
         end
         S_EVICT: state_in = S_INIT;
         S_WRITE: begin cmd.op = bblru_pkg::OP_WRITE; state_in = S_PROMO; end
         S_PROMO: begin
            cmd.op = bblru_pkg::OP_PROMOTE;
            if (sts.scan_last) state_in = S_RESULT;
         end
         S_RESULT: begin
            cmd.op = bblru_pkg::OP_RESULT; out_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_ff <= 1'b0; mode_ff <= '0; ins_ff <= 1'b0;
         st_ff <= 1'b0; fd_ff <= 1'b0; hd_ff <= 1'b0; after_ff <= S_IDLE;
      end else begin
         state_ff <= state_in; out_ff <= out_in; mode_ff <= mode_in;
         ins_ff <= ins_in; st_ff <= st_in; fd_ff <= fd_in; hd_ff <= hd_in;
         after_ff <= after_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("item taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESULT |=> rsp_valid)
      else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");
endmodule
`default_nettype wire

@@ rtl/byte_budget_lru_cache_directory.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_directory
// Byte-budgeted LRU directory over 64-bit keys, one item at a time.
// ----------------------------------------------------------------------------
// One item is handled at a time. Each key search walks the table one slot per
// cycle, as does each rank update after a removal or a promotion. A rejected
// insert, a clear or an unused mode skips the walks; contains and a lookup or
// erase that misses take one search; a lookup or erase that hits adds a rank
// update; an insert takes a search, the write and a rank update, and adds a
// rank update and a new search for every entry it replaces or evicts. The
// result register holds one item; the next item is taken in the cycle after
// it has been collected, at the earliest.
module byte_budget_lru_cache_directory #(
   parameter int ENTRIES = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  bblru_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output bblru_pkg::rsp_type  rsp_payload,
   input  wire                 csr_write,
   input  wire  [0:0]          csr_index,
   input  wire  [31:0]         csr_wdata
);
   logic [31:0] budget_ff;
   logic [15:0] overhead_ff;
   bblru_pkg::cmd_type cmd;
   bblru_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff   <= 32'd67108864;
         overhead_ff <= 16'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            bblru_pkg::CSR_BUDGET:   budget_ff   <= csr_wdata;
            bblru_pkg::CSR_OVERHEAD: overhead_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   bblru_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_mode(req_payload.mode),
      .rsp_valid, .rsp_stall, .cmd, .sts
   );

   bblru_datapath #(.ENTRIES(ENTRIES)) u_dp (
      .clock, .reset, .cmd, .sts, .req_payload,
      .budget(budget_ff), .overhead(overhead_ff), .rsp_payload
   );
endmodule
`default_nettype wire
